### src/qpht_pkg.sv
// ----------------------------------------------------------------------------
// qpht_pkg
// Shared types and constants for the quadratic-probe hash table.
// ----------------------------------------------------------------------------
package qpht_pkg;

    localparam int KEY_W      = 32;
    localparam int SLOT_W     = 4;
    localparam int STATUS_W   = 3;
    localparam int KEY_IDX_W  = 5;           // bit index into a key
    localparam int HASH_STEPS = KEY_W / 2;   // two key bits folded per cycle
    localparam int HASH_CNT_W = 4;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STAT_INSERTED  = 3'd0,
        STAT_FULL      = 3'd1,
        STAT_FOUND     = 3'd2,
        STAT_NOT_FOUND = 3'd3,
        STAT_BAD_KEY   = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_EMIT
    } state_t;

endpackage

### src/qpht_if.sv
// ----------------------------------------------------------------------------
// qpht_req_if / qpht_rsp_if
// Valid/ready channels for hash table requests and responses.
// ----------------------------------------------------------------------------
interface qpht_req_if;
    logic                       valid;
    logic                       ready;
    logic                       action;
    logic [qpht_pkg::KEY_W-1:0] key;

    modport source (output valid, output action, output key, input ready);
    modport sink   (input valid, input action, input key, output ready);
endinterface

interface qpht_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [qpht_pkg::SLOT_W-1:0]   slot;
    logic [qpht_pkg::STATUS_W-1:0] status;

    modport source (output valid, output slot, output status, input ready);
    modport sink   (input valid, input slot, input status, output ready);
endinterface

### src/qpht_key_ram.sv
// ----------------------------------------------------------------------------
// qpht_key_ram
// Key store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module qpht_key_ram #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [ADDR_W-1:0]          waddr,
    input  logic [qpht_pkg::KEY_W-1:0] wdata,
    input  logic [ADDR_W-1:0]          raddr,
    output logic [qpht_pkg::KEY_W-1:0] rdata
);

    logic [qpht_pkg::KEY_W-1:0] mem [DEPTH];
    logic [qpht_pkg::KEY_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### src/quadratic_probe_hash_table.sv
// ----------------------------------------------------------------------------
// quadratic_probe_hash_table
// Open-addressing key table with quadratic probing: insert and search.
// ----------------------------------------------------------------------------
// One request is handled at a time. After reset the table is cleared by a
// pass that writes one slot per cycle before the first request is taken. A
// request is then accepted, the key is reduced modulo TABLE_SLOTS (skipped
// when TABLE_SLOTS is a power of two), the probes read the key store with
// one key store read per cycle and registered read data, and the result is
// loaded into the response register. The single read port of the key store
// sets the probe rate. Key zero is answered without touching the table. The
// response register lets the next request be accepted while the previous
// response is still waiting.
// ----------------------------------------------------------------------------
module quadratic_probe_hash_table #(
    parameter int TABLE_SLOTS = 16
) (
    input logic         clk,
    input logic         rst_n,
    qpht_req_if.sink    req,
    qpht_rsp_if.source  rsp
);

    localparam int   AW      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int   CW      = $clog2(TABLE_SLOTS + 1);
    localparam logic IS_POW2 = ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0);

    // s < 2*TABLE_SLOTS -> s mod TABLE_SLOTS
    function automatic logic [AW-1:0] mod_fold(input logic [AW:0] s);
        logic [AW:0] r;
        begin
            r = s;
            if (s >= (AW+1)'(TABLE_SLOTS))
            begin
                r = s - (AW+1)'(TABLE_SLOTS);
            end
            return r[AW-1:0];
        end
    endfunction

    qpht_pkg::state_t  state_reg, state_next;
    logic [AW-1:0]     clr_cnt_reg, clr_cnt_next;
    logic              act_reg, act_next;
    logic [qpht_pkg::KEY_W-1:0] key_reg, key_next;
    logic [AW-1:0]     rem_reg, rem_next;
    logic [qpht_pkg::HASH_CNT_W-1:0] step_reg, step_next;
    logic [AW-1:0]     pos_reg, pos_next;
    logic [AW-1:0]     delta_reg, delta_next;
    logic [CW-1:0]     issue_cnt_reg, issue_cnt_next;
    logic              rd_vld_reg, rd_vld_next;
    logic [AW-1:0]     rd_pos_reg, rd_pos_next;
    logic              rd_last_reg, rd_last_next;
    logic [qpht_pkg::SLOT_W-1:0] res_slot_reg, res_slot_next;
    qpht_pkg::status_t res_status_reg, res_status_next;
    logic              out_vld_reg, out_vld_next;
    logic [qpht_pkg::SLOT_W-1:0] out_slot_reg, out_slot_next;
    qpht_pkg::status_t out_status_reg, out_status_next;

    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [qpht_pkg::KEY_W-1:0] ram_wdata;
    logic [AW-1:0]              ram_raddr;
    logic [qpht_pkg::KEY_W-1:0] ram_rdata;

    qpht_key_ram #(
        .DEPTH  (TABLE_SLOTS),
        .ADDR_W (AW)
    ) u_key_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= qpht_pkg::S_CLEAR;
            clr_cnt_reg   <= '0;
            issue_cnt_reg <= '0;
            step_reg      <= '0;
            rd_vld_reg    <= 1'b0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            issue_cnt_reg <= issue_cnt_next;
            step_reg      <= step_next;
            rd_vld_reg    <= rd_vld_next;
            out_vld_reg   <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        key_reg        <= key_next;
        rem_reg        <= rem_next;
        pos_reg        <= pos_next;
        delta_reg      <= delta_next;
        rd_pos_reg     <= rd_pos_next;
        rd_last_reg    <= rd_last_next;
        res_slot_reg   <= res_slot_next;
        res_status_reg <= res_status_next;
        out_slot_reg   <= out_slot_next;
        out_status_reg <= out_status_next;
    end

    always_comb
    begin
        logic [qpht_pkg::KEY_IDX_W-1:0] bit_hi;
        logic [AW-1:0]                  fold1;
        logic [AW-1:0]                  fold2;
        logic                           finish;

        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        act_next        = act_reg;
        key_next        = key_reg;
        rem_next        = rem_reg;
        step_next       = step_reg;
        pos_next        = pos_reg;
        delta_next      = delta_reg;
        issue_cnt_next  = issue_cnt_reg;
        rd_vld_next     = 1'b0;
        rd_pos_next     = pos_reg;
        rd_last_next    = (issue_cnt_reg == CW'(TABLE_SLOTS - 1));
        res_slot_next   = res_slot_reg;
        res_status_next = res_status_reg;
        out_vld_next    = out_vld_reg && !rsp.ready;
        out_slot_next   = out_slot_reg;
        out_status_next = out_status_reg;

        ram_we    = 1'b0;
        ram_waddr = rd_pos_reg;
        ram_wdata = key_reg;
        ram_raddr = pos_reg;
        finish    = 1'b0;

        // two key bits per cycle, MSB first: rem = (2*rem + bit) mod N, twice
        bit_hi = qpht_pkg::KEY_IDX_W'(qpht_pkg::KEY_W - 1) - {step_reg, 1'b0};
        fold1  = mod_fold({rem_reg, key_reg[bit_hi]});
        fold2  = mod_fold({fold1, key_reg[bit_hi - qpht_pkg::KEY_IDX_W'(1)]});

        case (state_reg)
            qpht_pkg::S_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(TABLE_SLOTS - 1))
                begin
                    state_next = qpht_pkg::S_IDLE;
                end
            end

            qpht_pkg::S_IDLE:
            begin
                if (req.valid)
                begin
                    act_next       = req.action;
                    key_next       = req.key;
                    rem_next       = '0;
                    step_next      = '0;
                    pos_next       = req.key[AW-1:0];
                    delta_next     = AW'(1);
                    issue_cnt_next = '0;
                    if (req.key == '0)
                    begin
                        res_slot_next   = '0;
                        res_status_next = qpht_pkg::STAT_BAD_KEY;
                        state_next      = qpht_pkg::S_EMIT;
                    end
                    else if (IS_POW2)
                    begin
                        state_next = qpht_pkg::S_PROBE;
                    end
                    else
                    begin
                        state_next = qpht_pkg::S_HASH;
                    end
                end
            end

            qpht_pkg::S_HASH:
            begin
                rem_next  = fold2;
                step_next = step_reg + qpht_pkg::HASH_CNT_W'(1);
                if (step_reg == qpht_pkg::HASH_CNT_W'(qpht_pkg::HASH_STEPS - 1))
                begin
                    pos_next   = fold2;
                    delta_next = AW'(1);
                    state_next = qpht_pkg::S_PROBE;
                end
            end

            qpht_pkg::S_PROBE:
            begin
                // issue the next probe address every cycle until TABLE_SLOTS probes have
                // been issued; the address sequence does not depend on the data read back
                if (issue_cnt_reg != CW'(TABLE_SLOTS))
                begin
                    rd_vld_next    = 1'b1;
                    issue_cnt_next = issue_cnt_reg + CW'(1);
                    pos_next       = mod_fold({1'b0, pos_reg} + {1'b0, delta_reg});
                    delta_next     = mod_fold({1'b0, delta_reg} + (AW+1)'(2));
                end

                if (rd_vld_reg)
                begin
                    if (act_reg == qpht_pkg::ACT_INSERT)
                    begin
                        if (ram_rdata == '0)
                        begin
                            ram_we          = 1'b1;
                            res_slot_next   = qpht_pkg::SLOT_W'(rd_pos_reg);
                            res_status_next = qpht_pkg::STAT_INSERTED;
                            finish          = 1'b1;
                        end
                        else if (rd_last_reg)
                        begin
                            res_slot_next   = '0;
                            res_status_next = qpht_pkg::STAT_FULL;
                            finish          = 1'b1;
                        end
                    end
                    else
                    begin
                        if (ram_rdata == key_reg)
                        begin
                            res_slot_next   = qpht_pkg::SLOT_W'(rd_pos_reg);
                            res_status_next = qpht_pkg::STAT_FOUND;
                            finish          = 1'b1;
                        end
                        else if (ram_rdata == '0 || rd_last_reg)
                        begin
                            res_slot_next   = '0;
                            res_status_next = qpht_pkg::STAT_NOT_FOUND;
                            finish          = 1'b1;
                        end
                    end
                end

                if (finish)
                begin
                    rd_vld_next = 1'b0;   // drop the read in flight
                    state_next  = qpht_pkg::S_EMIT;
                end
            end

            qpht_pkg::S_EMIT:
            begin
                if (!out_vld_reg || rsp.ready)
                begin
                    out_vld_next    = 1'b1;
                    out_slot_next   = res_slot_reg;
                    out_status_next = res_status_reg;
                    state_next      = qpht_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = qpht_pkg::S_IDLE;
            end
        endcase
    end

    assign req.ready  = (state_reg == qpht_pkg::S_IDLE);
    assign rsp.valid  = out_vld_reg;
    assign rsp.slot   = out_slot_reg;
    assign rsp.status = out_status_reg;

endmodule

### src/qpht_checker.sv
// ----------------------------------------------------------------------------
// qpht_checker
// Port-level checks for the quadratic-probe hash table, bound to the top.
// ----------------------------------------------------------------------------
module qpht_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [qpht_pkg::SLOT_W-1:0]   rsp_slot,
    input logic [qpht_pkg::STATUS_W-1:0] rsp_status
);

    // a stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_slot) && $stable(rsp_status))
        else $error("response changed while stalled");

    // one request in flight: no accept right after an accept
    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while another is in flight");

    // failures carry no slot
    a_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == qpht_pkg::STAT_FULL
                   || rsp_status == qpht_pkg::STAT_NOT_FOUND
                   || rsp_status == qpht_pkg::STAT_BAD_KEY)
        |-> rsp_slot == '0)
        else $error("failure response with nonzero slot");

    // in reset: no response and no request taken (table still clearing)
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !rsp_valid && !req_ready)
        else $error("activity during reset");

endmodule

bind quadratic_probe_hash_table qpht_checker u_qpht_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_slot   (rsp.slot),
    .rsp_status (rsp.status)
);

### sim/tb_quadratic_probe_hash_table.sv
// ----------------------------------------------------------------------------
// tb_quadratic_probe_hash_table
// Drives insert and search requests into the quadratic-probe hash table and
// checks every response against a shadow copy of the key table. Directed
// tests cover key zero, full probe chains, empty home slots, duplicates and
// key extremes. A long random run follows with bursty requests and
// backpressure on the response side.
// ----------------------------------------------------------------------------
module tb_quadratic_probe_hash_table;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_SLOTS  = 16;
    localparam int RANDOM_COUNT = 1830;

    typedef struct packed {
        logic [qpht_pkg::SLOT_W-1:0] slot;
        qpht_pkg::status_t           status;
    } table_rsp_t;

    logic clk;
    logic rst_n;

    qpht_req_if req_if();
    qpht_rsp_if rsp_if();

    quadratic_probe_hash_table #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    logic [qpht_pkg::KEY_W-1:0] shadow_keys [TABLE_SLOTS];
    logic [qpht_pkg::KEY_W-1:0] stored_keys [$];
    table_rsp_t                 pending_rsp [$];
    int                         err_count;
    int                         burst_left;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n <= 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Shadow of the key table: works out the response and applies any insert
    function automatic table_rsp_t predict_table_op(input logic act,
                                                    input logic [qpht_pkg::KEY_W-1:0] k);
        table_rsp_t       r;
        int unsigned      home;
        int unsigned      p;
        begin
            r.slot   = '0;
            home     = k % TABLE_SLOTS;
            if (k == '0)
            begin
                r.status = qpht_pkg::STAT_BAD_KEY;
            end
            else if (act == qpht_pkg::ACT_INSERT)
            begin
                r.status = qpht_pkg::STAT_FULL;
                for (int i = 0; i < TABLE_SLOTS; i++)
                begin
                    p = (home + i * i) % TABLE_SLOTS;
                    if (shadow_keys[p] == '0)
                    begin
                        shadow_keys[p] = k;
                        r.slot   = p[qpht_pkg::SLOT_W-1:0];
                        r.status = qpht_pkg::STAT_INSERTED;
                        break;
                    end
                end
            end
            else
            begin
                r.status = qpht_pkg::STAT_NOT_FOUND;
                for (int i = 0; i < TABLE_SLOTS; i++)
                begin
                    p = (home + i * i) % TABLE_SLOTS;
                    if (shadow_keys[p] == k)
                    begin
                        r.slot   = p[qpht_pkg::SLOT_W-1:0];
                        r.status = qpht_pkg::STAT_FOUND;
                        break;
                    end
                    if (shadow_keys[p] == '0)
                        break;
                end
            end
            return r;
        end
    endfunction

    // Called at a falling edge; returns at a falling edge
    task automatic send_request(input logic act, input logic [qpht_pkg::KEY_W-1:0] k);
        table_rsp_t exp_rsp;
        begin
            req_if.valid  <= 1'b1;
            req_if.action <= act;
            req_if.key    <= k;
            @(posedge clk);
            while (!req_if.ready)
                @(posedge clk);
            exp_rsp = predict_table_op(act, k);
            pending_rsp.push_back(exp_rsp);
            if (act == qpht_pkg::ACT_INSERT && k != '0)
                stored_keys.push_back(k);
            @(negedge clk);
            if (burst_left > 0)
            begin
                burst_left--;
            end
            else
            begin
                req_if.valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge clk);
                if ($urandom_range(0, 3) == 0)
                    burst_left = $urandom_range(50, 150);
                else
                    burst_left = $urandom_range(0, 15);
            end
        end
    endtask

    task automatic go_quiet();
        begin
            req_if.valid <= 1'b0;
            @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        begin
            go_quiet();
            while (pending_rsp.size() != 0)
                @(negedge clk);
        end
    endtask

    function automatic logic [qpht_pkg::KEY_W-1:0] pick_key();
        int r;
        begin
            r = $urandom_range(0, 99);
            if (r < 6)
                return '0;
            else if (r < 30)
                return $urandom;
            else if (r < 55 || stored_keys.size() == 0)
                return $urandom_range(1, 64);
            else
                return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
        end
    endfunction

    task automatic test_key_zero();
        begin
            send_request(qpht_pkg::ACT_INSERT, '0);
            send_request(qpht_pkg::ACT_SEARCH, '0);
        end
    endtask

    task automatic test_key_extremes();
        begin
            send_request(qpht_pkg::ACT_INSERT, 32'hFFFF_FFFF);
            send_request(qpht_pkg::ACT_SEARCH, 32'hFFFF_FFFF);
            send_request(qpht_pkg::ACT_INSERT, 32'h8000_0000);
            send_request(qpht_pkg::ACT_SEARCH, 32'h8000_0000);
        end
    endtask

    task automatic test_empty_home();
        begin
            send_request(qpht_pkg::ACT_SEARCH, 32'd5);
        end
    endtask

    // Home slot 3 only ever visits slots 3, 4, 7 and 12
    task automatic test_probe_chain();
        begin
            send_request(qpht_pkg::ACT_INSERT, 32'd3);
            send_request(qpht_pkg::ACT_INSERT, 32'd19);
            send_request(qpht_pkg::ACT_INSERT, 32'd35);
            send_request(qpht_pkg::ACT_INSERT, 32'd51);
            send_request(qpht_pkg::ACT_INSERT, 32'd67);
            send_request(qpht_pkg::ACT_SEARCH, 32'd51);
            send_request(qpht_pkg::ACT_SEARCH, 32'd67);
            send_request(qpht_pkg::ACT_SEARCH, 32'd20);
        end
    endtask

    task automatic test_duplicate_insert();
        begin
            send_request(qpht_pkg::ACT_INSERT, 32'd5);
            send_request(qpht_pkg::ACT_INSERT, 32'd5);
            send_request(qpht_pkg::ACT_SEARCH, 32'd5);
        end
    endtask

    task automatic test_random_traffic();
        logic act;
        begin
            for (int n = 0; n < RANDOM_COUNT; n++)
            begin
                if (n == RANDOM_COUNT / 2)
                    wait_drained();
                act = ($urandom_range(0, 99) < 40) ? qpht_pkg::ACT_INSERT
                                                   : qpht_pkg::ACT_SEARCH;
                send_request(act, pick_key());
            end
        end
    endtask

    // Response side stalls in phases: always ready, coin flip, long stalls
    initial
    begin
        int mode;
        int stall_left;
        rsp_if.ready = 1'b0;
        stall_left   = 0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 2);
            repeat ($urandom_range(64, 256))
            begin
                @(negedge clk);
                case (mode)
                    0: rsp_if.ready <= 1'b1;
                    1: rsp_if.ready <= 1'($urandom_range(0, 1));
                    default:
                    begin
                        if (stall_left > 0)
                        begin
                            stall_left--;
                            rsp_if.ready <= 1'b0;
                        end
                        else if ($urandom_range(0, 19) == 0)
                        begin
                            stall_left = $urandom_range(5, 30);
                            rsp_if.ready <= 1'b0;
                        end
                        else
                        begin
                            rsp_if.ready <= 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        table_rsp_t exp_rsp;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                err_count++;
                $display("%0t: unexpected response slot=%0d status=%0d",
                         $time, rsp_if.slot, rsp_if.status);
            end
            else
            begin
                exp_rsp = pending_rsp.pop_front();
                if (rsp_if.slot !== exp_rsp.slot)
                begin
                    err_count++;
                    $display("%0t: slot mismatch expected %0d actual %0d",
                             $time, exp_rsp.slot, rsp_if.slot);
                end
                if (rsp_if.status !== exp_rsp.status)
                begin
                    err_count++;
                    $display("%0t: status mismatch expected %0d actual %0d",
                             $time, exp_rsp.status, rsp_if.status);
                end
            end
        end
    end

    initial
    begin
        err_count     = 0;
        burst_left    = 0;
        req_if.valid  = 1'b0;
        req_if.action = qpht_pkg::ACT_INSERT;
        req_if.key    = '0;
        foreach (shadow_keys[i])
            shadow_keys[i] = '0;

        @(posedge rst_n);
        @(negedge clk);

        test_key_zero();
        test_key_extremes();
        test_empty_home();
        test_probe_chain();
        test_duplicate_insert();
        test_random_traffic();

        go_quiet();
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);

        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
